// ----- sv/gph_pkg.sv -----
// Shared types, codes and the fingerprint function of the group probe hash set.
package gph_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  localparam logic [7:0] EMPTY_TAG = 8'hFF;

  // Fold the low 16 bits of the key modulo 255 (byte sum, end-around carry).
  function automatic logic [7:0] fingerprint(input logic [63:0] key);
    logic [8:0] sum;
    logic [7:0] fold;
    sum  = {1'b0, key[15:8]} + {1'b0, key[7:0]};
    fold = sum[7:0] + {7'd0, sum[8]};
    return (fold == 8'hFF) ? 8'h00 : fold;
  endfunction

endpackage

// ----- sv/group_probe_hash_set.sv -----
// Top level: open-addressing hash set with tag and key memories and a probe sequencer.
// Insert/find probe the window slot by slot, S_RD issuing each read and S_EV evaluating it;
//   a probe past the store's end or opcode 3 answers straight from idle, without probing.
// Clear sweeps all TABLE_SLOTS + GROUP_WIDTH tag slots, one slot a cycle, then answers.
// One request at a time: busy, when raised, stays high until the result strobe (done).
// Reset runs the same sweep over all slots with busy high, but gives no result.
// The result strobe lasts one cycle and cannot be stalled.
module group_probe_hash_set #(
  parameter int TABLE_SLOTS = 4096,
  parameter int GROUP_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [11:0] start_slot,
  input  logic [63:0] key_value,
  output logic        done,
  output logic        found_flag,
  output logic        full_flag
);

  localparam int DEPTH = TABLE_SLOTS + GROUP_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int OW    = $clog2(GROUP_WIDTH);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EV} state_t;

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic          clr_reply;
  logic [BW-1:0] base;
  logic [OW-1:0] off;
  logic          is_find;
  logic          saw_empty;
  logic [7:0]    fp;
  logic [63:0]   key_reg;

  logic [AW-1:0] addr;
  logic [BW-1:0] slot;
  logic [BW:0]   base_next;
  logic          tag_we, key_we;
  logic [7:0]    tag_wdata, tag_rdata;
  logic [63:0]   key_rdata;
  logic          slot_empty, hit, empty_now, start_fits;

  // Slot under probe: window base plus offset within the window.
  assign slot       = base + BW'(off);
  assign addr       = (state == S_CLR) ? clr_cnt : slot[AW-1:0];
  assign slot_empty = (tag_rdata == gph_pkg::EMPTY_TAG);
  assign hit        = (tag_rdata == fp) && (key_rdata == key_reg);
  assign empty_now  = saw_empty | slot_empty;
  assign base_next  = {1'b0, base} + (BW+1)'(GROUP_WIDTH);
  // A window fits when its base is at most TABLE_SLOTS.
  assign start_fits = {20'd0, start_slot} <= 32'(TABLE_SLOTS);

  // Insert claims the first empty slot met; the sweep writes the empty tag.
  assign key_we    = (state == S_EV) && !is_find && slot_empty;
  assign tag_we    = (state == S_CLR) || key_we;
  assign tag_wdata = (state == S_CLR) ? gph_pkg::EMPTY_TAG : fp;
  assign busy      = (state != S_IDLE);

  gph_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tag_ram (
    .clk(clk), .we(tag_we), .addr(addr), .wdata(tag_wdata), .rdata(tag_rdata)
  );

  gph_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .addr(addr), .wdata(key_reg), .rdata(key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_reply  <= 1'b0;
      done       <= 1'b0;
      found_flag <= 1'b0;
      full_flag  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_reg   <= key_value;
            fp        <= gph_pkg::fingerprint(key_value);
            is_find   <= (opcode == gph_pkg::OP_FIND);
            saw_empty <= 1'b0;
            off       <= '0;
            unique case (opcode) inside
              gph_pkg::OP_INSERT, gph_pkg::OP_FIND: begin
                if (start_fits) begin
                  base  <= BW'(start_slot);
                  state <= S_RD;
                end else begin
                  // Start window already runs past the end: report full.
                  done       <= 1'b1;
                  found_flag <= 1'b0;
                  full_flag  <= 1'b1;
                end
              end
              gph_pkg::OP_CLEAR: begin
                clr_cnt   <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: begin
                done       <= 1'b1;
                found_flag <= 1'b0;
                full_flag  <= 1'b0;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if ((!is_find && slot_empty) || (is_find && hit)) begin
            done       <= 1'b1;
            found_flag <= 1'b1;
            full_flag  <= 1'b0;
            state      <= S_IDLE;
          end else if (off == OW'(GROUP_WIDTH - 1)) begin
            if (is_find && empty_now) begin
              // Window held an empty slot: key cannot lie further on.
              done       <= 1'b1;
              found_flag <= 1'b0;
              full_flag  <= 1'b0;
              state      <= S_IDLE;
            end else if (base_next > (BW+1)'(TABLE_SLOTS)) begin
              done       <= 1'b1;
              found_flag <= 1'b0;
              full_flag  <= 1'b1;
              state      <= S_IDLE;
            end else begin
              base      <= base_next[BW-1:0];
              off       <= '0;
              saw_empty <= 1'b0;
              state     <= S_RD;
            end
          end else begin
            off       <= off + 1'b1;
            saw_empty <= empty_now;
            state     <= S_RD;
          end
        end
        S_CLR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state     <= S_IDLE;
            clr_reply <= 1'b0;
            if (clr_reply) begin
              done       <= 1'b1;
              found_flag <= 1'b0;
              full_flag  <= 1'b0;
            end
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reset_sweeps: assert property (@(posedge clk) rst |=> (state == S_CLR && busy))
    else $error("reset did not start the clearing sweep");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found_flag && full_flag))
    else $error("found and full reported together");
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request accepted without work or result");
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (slot < BW'(DEPTH)))
    else $error("key write outside the store");

endmodule

// ----- sv/gph_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module gph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
